// File: hw/rtl/bbs_pkg.sv
// shared types and constants for the block boundary search core
package bbs_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int OFS_W   = 17;
  localparam int CNT_W   = 9;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index taken from paddr[2]
  localparam logic REG_NUM_BLOCKS = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD       = 2'd0,
    OP_FIND_END   = 2'd1,
    OP_FIND_START = 2'd2,
    OP_UNUSED     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD       = 2'd0,
    CMD_FIND_END   = 2'd1,
    CMD_FIND_START = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [IDX_W-1:0] entry_index;
    logic [OFS_W-1:0] entry_start;
    logic [OFS_W-1:0] entry_end;
    logic [OFS_W-1:0] key;
  } cmd_t;

endpackage

// File: hw/rtl/bbs_in_if.sv
// input item channel
interface bbs_in_if;
  import bbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] entry_index;
  logic [OFS_W-1:0] entry_start;
  logic [OFS_W-1:0] entry_end;
  logic [OFS_W-1:0] key;

  modport source (
    output valid, op, entry_index, entry_start, entry_end, key,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, entry_start, entry_end, key,
    output ready
  );
endinterface

// File: hw/rtl/bbs_out_if.sv
// result item channel
interface bbs_out_if;
  import bbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] block_index;
  logic             found;

  modport source (
    output valid, block_index, found,
    input  ready
  );

  modport sink (
    input  valid, block_index, found,
    output ready
  );
endinterface

// File: hw/rtl/bbs_ram.sv
// generic single-port ram with registered read
module bbs_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bbs_front.sv
// front end: accepts input transfers, classifies them and queues commands
module bbs_front #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bbs_in_if.sink        in_i,
  output logic          cmd_valid_o,
  output bbs_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import bbs_pkg::*;

  cmd_t        q_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  logic        pop;
  logic        in_range;
  cmd_t        cmd_new;

  assign in_range = 32'(in_i.entry_index) < 32'(MAX_BLOCKS);

  always_comb begin
    cmd_new.entry_index = in_i.entry_index;
    cmd_new.entry_start = in_i.entry_start;
    cmd_new.entry_end   = in_i.entry_end;
    cmd_new.key         = in_i.key;
    case (op_e'(in_i.op))
      OP_LOAD:       cmd_new.kind = in_range ? CMD_LOAD : CMD_NOP;
      OP_FIND_END:   cmd_new.kind = CMD_FIND_END;
      OP_FIND_START: cmd_new.kind = CMD_FIND_START;
      OP_UNUSED:     cmd_new.kind = CMD_NOP;
      default:       cmd_new.kind = CMD_NOP;
    endcase
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: hw/rtl/bbs_back.sv
// back end: table writes, binary search sequencer and output register
module bbs_back #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bbs_pkg::CNT_W-1:0] num_blocks_i,
  input  logic                      cmd_valid_i,
  input  bbs_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  bbs_out_if.source                 out_o
);
  import bbs_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int NW = (CW > CNT_W) ? CW : CNT_W;
  localparam int DW = 2 * OFS_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_STEP  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    h_q, h_d;
  logic [CW-1:0]    l_q, l_d;
  logic [CW-1:0]    m_q, m_d;
  logic [OFS_W-1:0] key_q, key_d;
  logic             col_end_q, col_end_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic             res_found_q, res_found_d;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_found_q;
  logic             out_free;
  logic             out_load;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [DW-1:0]    ram_wdata;
  logic [DW-1:0]    ram_rdata;
  logic [OFS_W-1:0] rd_col;

  logic [NW-1:0]    cnt_wide;
  logic [CW-1:0]    n_eff;

  logic             plan;
  logic [CW-1:0]    ph, pl;
  logic [CW-1:0]    pdiff;
  logic [CW:0]      psum;
  logic [CW-1:0]    pmid;
  logic [CW-1:0]    pmid_m1;
  logic [CW-1:0]    ph_m1;
  logic [CW-1:0]    h_m1;

  logic             fin;
  logic [IDX_W-1:0] fin_idx;
  logic             fin_found;

  assign cnt_wide = NW'(num_blocks_i);
  assign n_eff    = (cnt_wide > NW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(cnt_wide);
  assign rd_col   = col_end_q ? ram_rdata[OFS_W-1:0] : ram_rdata[DW-1:OFS_W];
  assign out_free = !out_valid_q || out_o.ready;
  assign h_m1     = h_q - CW'(1);

  assign pdiff   = ph - pl;
  assign psum    = {1'b0, ph} + {1'b0, pl};
  assign pmid    = CW'(psum >> 1);
  assign pmid_m1 = pmid - CW'(1);
  assign ph_m1   = ph - CW'(1);

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    l_d         = l_q;
    m_d         = m_q;
    key_d       = key_q;
    col_end_d   = col_end_q;
    res_idx_d   = res_idx_q;
    res_found_d = res_found_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = {cmd_i.entry_start, cmd_i.entry_end};
    plan        = 1'b0;
    ph          = '0;
    pl          = '0;
    fin         = 1'b0;
    fin_idx     = '0;
    fin_found   = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_LOAD: begin
              ram_we   = 1'b1;
              ram_addr = AW'(cmd_i.entry_index);
              fin      = 1'b1;
            end
            CMD_FIND_END, CMD_FIND_START: begin
              key_d     = cmd_i.key;
              col_end_d = (cmd_i.kind == CMD_FIND_END);
              ph        = n_eff;
              pl        = '0;
              plan      = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_STEP: begin
        ph   = h_q;
        pl   = l_q;
        plan = 1'b1;
        if (key_q <= rd_col) begin
          ph = m_q;
        end else begin
          pl = m_q;
        end
      end
      ST_CHECK: begin
        fin       = 1'b1;
        fin_found = (rd_col == key_q);
        fin_idx   = fin_found ? IDX_W'(h_m1) : '0;
      end
      ST_DONE: begin
        fin       = 1'b1;
        fin_idx   = res_idx_q;
        fin_found = res_found_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // one probe per cycle: the next read address follows from this compare
    if (plan) begin
      h_d = ph;
      l_d = pl;
      if (pdiff > CW'(1)) begin
        ram_addr = AW'(pmid_m1);
        m_d      = pmid;
        state_d  = ST_STEP;
      end else if (ph == '0) begin
        fin = 1'b1;
      end else begin
        ram_addr = AW'(ph_m1);
        state_d  = ST_CHECK;
      end
    end

    if (fin) begin
      if (out_free) begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end else begin
        res_idx_d   = fin_idx;
        res_found_d = fin_found;
        state_d     = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q         <= h_d;
    l_q         <= l_d;
    m_q         <= m_d;
    key_q       <= key_d;
    col_end_q   <= col_end_d;
    res_idx_q   <= res_idx_d;
    res_found_q <= res_found_d;
    if (out_load) begin
      out_idx_q   <= fin_idx;
      out_found_q <= fin_found;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.block_index = out_idx_q;
  assign out_o.found       = out_found_q;

  bbs_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// File: hw/rtl/block_boundary_search_core.sv
// top level of the block boundary search core
// The core keeps a table of MAX_BLOCKS blocks, each a start and an end offset,
// in one RAM with a single port. A load transfer writes one entry. A query runs a
// lower-bound binary search over the first num_blocks entries of the end or start
// column and returns the index of the entry at the final bound with a found flag,
// or index zero when no entry matches. It makes one RAM probe per cycle, bounded
// by that one read port. A two-entry command queue sits between input and search,
// and the result register lets the next command start while a result waits. Write
// num_blocks only while the core is idle.
module block_boundary_search_core #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bbs_in_if.sink                      in_i,
  bbs_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbs_pkg::PADDR_W-1:0] paddr,
  input  logic [bbs_pkg::PDATA_W-1:0] pwdata,
  output logic [bbs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import bbs_pkg::*;

  logic [CNT_W-1:0] num_blocks_q, num_blocks_d;
  logic             cfg_wr;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_BLOCKS);
  assign num_blocks_d = cfg_wr ? pwdata[CNT_W-1:0] : num_blocks_q;
  assign prdata = (paddr[2] == REG_NUM_BLOCKS) ? PDATA_W'(num_blocks_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_blocks_q <= '0;
    end else begin
      num_blocks_q <= num_blocks_d;
    end
  end

  bbs_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bbs_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_blocks_i (num_blocks_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_o        (out_o)
  );

endmodule

// File: tb/block_boundary_search_core_tb.sv
// testbench for block_boundary_search_core: random load and lookup traffic with a predictor
`timescale 1ns / 1ps

module block_boundary_search_core_tb;
  import bbs_pkg::*;

  localparam int MAX_BLOCKS = 256;
  localparam int MAX_OFS = (1 << OFS_W) - 1;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    op_e              op;
    logic [IDX_W-1:0] entry_index;
    logic [OFS_W-1:0] entry_start;
    logic [OFS_W-1:0] entry_end;
    logic [OFS_W-1:0] key;
  } block_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] block_index;
    logic             found;
  } lookup_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bbs_in_if in_if ();
  bbs_out_if out_if ();

  block_boundary_search_core #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  block_cmd_t queued_cmds[$];
  lookup_t expected_lookups[$];
  logic [OFS_W-1:0] shadow_start[MAX_BLOCKS];
  logic [OFS_W-1:0] shadow_end[MAX_BLOCKS];
  logic [CNT_W-1:0] blocks_in_use = '0;
  int plan_start[MAX_BLOCKS];
  int plan_end[MAX_BLOCKS];
  bit no_gaps = 1'b0;
  bit mismatch_seen = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic lookup_t search_column(input logic use_start, input logic [OFS_W-1:0] key);
    int n;
    int lo;
    int hi;
    int mid;
    logic [OFS_W-1:0] probe;
    lookup_t res;
    res = '0;
    n = (blocks_in_use > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_in_use);
    lo = -1;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      probe = use_start ? shadow_start[mid] : shadow_end[mid];
      if (key <= probe) hi = mid;
      else lo = mid;
    end
    if (hi >= 0) begin
      probe = use_start ? shadow_start[hi] : shadow_end[hi];
      if (probe == key) begin
        res.block_index = hi[IDX_W-1:0];
        res.found = 1'b1;
      end
    end
    return res;
  endfunction

  // driver: one pending command on the input channel, predictor updated per transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        case (op_e'(in_if.op))
          OP_LOAD: begin
            shadow_start[in_if.entry_index] = in_if.entry_start;
            shadow_end[in_if.entry_index] = in_if.entry_end;
            expected_lookups.push_back('0);
          end
          OP_FIND_END: expected_lookups.push_back(search_column(1'b0, in_if.key));
          OP_FIND_START: expected_lookups.push_back(search_column(1'b1, in_if.key));
          default: expected_lookups.push_back('0);
        endcase
        void'(queued_cmds.pop_front());
      end
      if (in_if.valid && !in_if.ready) begin
        in_if.valid <= 1'b1;
      end else if (queued_cmds.size() > 0 && (no_gaps || $urandom_range(99) >= 34)) begin
        in_if.valid <= 1'b1;
        in_if.op <= queued_cmds[0].op;
        in_if.entry_index <= queued_cmds[0].entry_index;
        in_if.entry_start <= queued_cmds[0].entry_start;
        in_if.entry_end <= queued_cmds[0].entry_end;
        in_if.key <= queued_cmds[0].key;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest predicted lookup
  always @(posedge clk_i) begin
    lookup_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_lookups.size() == 0) begin
          $error("result transfer with no lookup outstanding: block_index %0d, found %0d",
                 out_if.block_index, out_if.found);
          mismatch_seen = 1'b1;
        end else begin
          want = expected_lookups.pop_front();
          if (out_if.block_index !== want.block_index) begin
            $error("block_index: expected %0d, actual %0d", want.block_index, out_if.block_index);
            mismatch_seen = 1'b1;
          end
          if (out_if.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_if.found);
            mismatch_seen = 1'b1;
          end
        end
      end
      out_if.ready <= no_gaps || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_cmd(input op_e op, input int idx, input int s, input int e, input int key);
    block_cmd_t c;
    c.op = op;
    c.entry_index = idx[IDX_W-1:0];
    c.entry_start = s[OFS_W-1:0];
    c.entry_end = e[OFS_W-1:0];
    c.key = key[OFS_W-1:0];
    if (op == OP_LOAD) begin
      plan_start[idx] = s;
      plan_end[idx] = e;
    end
    queued_cmds.push_back(c);
  endtask

  task automatic push_load(input int idx, input int s, input int e);
    push_cmd(OP_LOAD, idx, s, e, $urandom_range(MAX_OFS));
  endtask

  task automatic push_query(input op_e op, input int key);
    push_cmd(op, $urandom_range(MAX_BLOCKS - 1), $urandom_range(MAX_OFS),
             $urandom_range(MAX_OFS), key);
  endtask

  task automatic drain;
    wait (queued_cmds.size() == 0 && expected_lookups.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_num_blocks(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_NUM_BLOCKS, 2'b00};
    pwdata <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    blocks_in_use = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[CNT_W-1:0] !== value) begin
      $error("num_blocks: expected %0d, actual %0d", value, prdata[CNT_W-1:0]);
      mismatch_seen = 1'b1;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // sorted fill of the whole table, optionally shifted so the last entry sits at the top offset
  task automatic fill_sorted(input int step_max, input bit pin_top);
    int s;
    int e;
    int s_shift;
    int e_shift;
    s = $urandom_range(step_max);
    e = $urandom_range(step_max);
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      plan_start[i] = s;
      plan_end[i] = e;
      s += $urandom_range(step_max);
      e += $urandom_range(step_max);
    end
    s_shift = pin_top ? MAX_OFS - plan_start[MAX_BLOCKS-1] : 0;
    e_shift = pin_top ? MAX_OFS - plan_end[MAX_BLOCKS-1] : 0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      push_load(i, plan_start[i] + s_shift, plan_end[i] + e_shift);
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input int n_items,
                           input int load_pct, input int noise_pct);
    int eff;
    int r;
    int idx;
    int lo_s;
    int hi_s;
    int lo_e;
    int hi_e;
    int key;
    op_e op;
    write_num_blocks(count);
    eff = (count > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
    @(negedge clk_i);
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      if (r < noise_pct) begin
        push_load($urandom_range(MAX_BLOCKS - 1), $urandom_range(MAX_OFS),
                  $urandom_range(MAX_OFS));
      end else if (r < noise_pct + load_pct) begin
        // rewrite an entry without breaking the ascending order
        idx = $urandom_range(MAX_BLOCKS - 1);
        lo_s = (idx > 0) ? plan_start[idx-1] : 0;
        hi_s = (idx < MAX_BLOCKS - 1) ? plan_start[idx+1] : MAX_OFS;
        lo_e = (idx > 0) ? plan_end[idx-1] : 0;
        hi_e = (idx < MAX_BLOCKS - 1) ? plan_end[idx+1] : MAX_OFS;
        push_load(idx, $urandom_range(hi_s, lo_s), $urandom_range(hi_e, lo_e));
      end else begin
        r = $urandom_range(99);
        op = (r < 3) ? OP_UNUSED : (r < 51) ? OP_FIND_END : OP_FIND_START;
        r = $urandom_range(99);
        idx = (eff > 0) ? $urandom_range(eff - 1) : 0;
        key = (op == OP_FIND_START) ? plan_start[idx] : plan_end[idx];
        if (eff == 0 || r >= 85) key = $urandom_range(MAX_OFS);
        else if (r >= 70) key = (r[0] ? key + 1 : key - 1) & MAX_OFS;
        push_query(op, key);
      end
    end
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_LOAD;
    in_if.entry_index = '0;
    in_if.entry_start = '0;
    in_if.entry_end = '0;
    in_if.key = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table right after reset
    push_query(OP_FIND_END, 0);
    push_query(OP_FIND_START, MAX_OFS);
    push_load(0, 0, 5);
    push_load(1, 6, 100);
    push_load(2, 101, 65536);
    push_load(3, 65537, MAX_OFS);
    push_load(MAX_BLOCKS - 1, MAX_OFS, MAX_OFS);
    drain();

    write_num_blocks(4);
    @(negedge clk_i);
    push_query(OP_FIND_END, 5);
    push_query(OP_FIND_END, MAX_OFS);
    push_query(OP_FIND_END, 100);
    push_query(OP_FIND_START, 0);
    push_query(OP_FIND_START, 65537);
    push_query(OP_FIND_START, 6);
    push_query(OP_FIND_END, 7);
    push_query(OP_FIND_START, MAX_OFS);
    push_query(OP_FIND_END, 0);
    push_cmd(OP_UNUSED, MAX_BLOCKS - 1, MAX_OFS, MAX_OFS, MAX_OFS);
    // break the order of entry 1 in both columns
    push_load(1, MAX_OFS, 0);
    push_query(OP_FIND_START, 101);
    push_query(OP_FIND_END, 100);
    drain();

    write_num_blocks(1);
    @(negedge clk_i);
    push_query(OP_FIND_END, 5);
    push_query(OP_FIND_START, 1);
    drain();

    write_num_blocks(0);
    @(negedge clk_i);
    push_query(OP_FIND_END, 5);
    drain();

    no_gaps = 1'b1;
    @(negedge clk_i);
    fill_sorted(511, 1'b0);
    drain();
    run_phase(256, 120, 0, 0);
    no_gaps = 1'b0;
    run_phase(511, 120, 10, 0);
    run_phase(1, 30, 0, 0);
    run_phase(2, 30, 5, 0);
    run_phase(3, 30, 5, 0);
    run_phase(CNT_W'($urandom_range(255, 4)), 120, 10, 3);

    @(negedge clk_i);
    fill_sorted(2, 1'b1);
    drain();
    run_phase(256, 150, 5, 0);
    run_phase(300, 80, 5, 0);
    run_phase(256, 100, 0, 20);
    run_phase(0, 20, 0, 0);

    @(negedge clk_i);
    fill_sorted(63, 1'b0);
    drain();
    run_phase(CNT_W'($urandom_range(256, 129)), 120, 10, 0);

    repeat (20) @(posedge clk_i);
    if (!mismatch_seen && expected_lookups.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
